// ===== hdl/urbc_pkg.sv =====
// ----------------------------------------------------------------------------
// urbc_pkg
// shared constants and types for the uart ring buffer controller
// ----------------------------------------------------------------------------
package urbc_pkg;

   // ring geometry, each ring holds one slot less than its depth
   localparam int RING_DEPTH = 16;
   localparam int PTR_W      = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
   localparam int USED_W     = PTR_W + 1;

   // fixed field widths
   localparam int KIND_W = 3;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 4;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_HOST_WRITE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_HOST_READ  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RX_BYTE    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TX_READY   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RX_CLEAR   = 3'd4;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [USED_W-1:0] used_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [KIND_W-1:0] kind_type;

endpackage

// ===== hdl/uart_ring_buffer_controller.sv =====
// ----------------------------------------------------------------------------
// uart_ring_buffer_controller
// receive and transmit ring buffers of a uart with host and line side events
// ----------------------------------------------------------------------------
// One item per cycle while results are taken; a stalled result register
// holds the flow. An accepted item lands in an input register; the short
// pointer compare and update logic then runs on it, updates the rings and
// loads the result register, from which the result is taken. The rate
// is set by that single pass between the two registers: with rsp_ready
// held high, req_ready stays high and items stream back to back. Each
// ring holds RING_DEPTH - 1 bytes in a small register array.
// Every result carries the receive occupancy, the transmit free space and
// the ready interrupt enable as they stand after the item. check_parity
// resets to 1 and is written through csr_wr_en / csr_wr_data.
// ----------------------------------------------------------------------------
module uart_ring_buffer_controller
   import urbc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   // item input
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                req_parity_error,
   input  logic                req_tx_ready,
   // result output
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_ok,
   output logic [BYTE_W-1:0]   rsp_read_data,
   output logic                rsp_tx_valid,
   output logic [BYTE_W-1:0]   rsp_tx_byte,
   output logic                rsp_rx_dropped,
   output logic [CNT_W-1:0]    rsp_rx_count,
   output logic [CNT_W-1:0]    rsp_tx_space,
   output logic                rsp_ready_irq_enable
);

   // ------------------------------------------------------------------
   // helpers
   // ------------------------------------------------------------------
   function automatic ptr_type ring_next(input ptr_type p);
      ring_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic used_type ring_used(input ptr_type head, input ptr_type tail);
      if (head >= tail) begin
         ring_used = {1'b0, head} - {1'b0, tail};
      end else begin
         ring_used = {1'b0, head} + USED_W'(RING_DEPTH) - {1'b0, tail};
      end
   endfunction

   // ------------------------------------------------------------------
   // state
   // ------------------------------------------------------------------
   logic     check_parity_ff;
   ptr_type  rx_head_ff, rx_head_in;
   ptr_type  rx_tail_ff, rx_tail_in;
   ptr_type  tx_head_ff, tx_head_in;
   ptr_type  tx_tail_ff, tx_tail_in;
   logic     irq_en_ff,  irq_en_in;

   // byte stores, never read before written
   byte_type rx_store_ff [RING_DEPTH];
   byte_type tx_store_ff [RING_DEPTH];
   logic     rx_wr_en;
   logic     tx_wr_en;

   // input register
   logic     s1_valid_ff;
   kind_type s1_kind_ff;
   byte_type s1_data_ff;
   logic     s1_perr_ff;
   logic     s1_txrdy_ff;

   // result register
   logic     rsp_valid_ff;
   logic     rsp_ok_ff,       rsp_ok_in;
   byte_type rsp_rdata_ff,    rsp_rdata_in;
   logic     rsp_txv_ff,      rsp_txv_in;
   byte_type rsp_txb_ff,      rsp_txb_in;
   logic     rsp_drop_ff,     rsp_drop_in;
   cnt_type  rsp_rx_count_ff, rsp_rx_count_in;
   cnt_type  rsp_tx_space_ff, rsp_tx_space_in;

   logic     advance;
   logic     tx_empty;
   logic     rx_empty;
   used_type rx_used;
   used_type tx_used;

   // ------------------------------------------------------------------
   // flow control: the input register moves on when the result register
   // is free or being emptied in the same cycle
   // ------------------------------------------------------------------
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // ------------------------------------------------------------------
   // item processing
   // ------------------------------------------------------------------
   assign tx_empty = (tx_head_ff == tx_tail_ff);
   assign rx_empty = (rx_head_ff == rx_tail_ff);

   always_comb begin
      rx_head_in   = rx_head_ff;
      rx_tail_in   = rx_tail_ff;
      tx_head_in   = tx_head_ff;
      tx_tail_in   = tx_tail_ff;
      irq_en_in    = irq_en_ff;
      rx_wr_en     = 1'b0;
      tx_wr_en     = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_rdata_in = '0;
      rsp_txv_in   = 1'b0;
      rsp_txb_in   = '0;
      rsp_drop_in  = 1'b0;

      unique case (s1_kind_ff)
         KIND_HOST_WRITE: begin
            if (tx_empty && s1_txrdy_ff) begin
               // transmitter idle and nothing queued: bypass the ring
               rsp_txv_in = 1'b1;
               rsp_txb_in = s1_data_ff;
               irq_en_in  = 1'b0;
               rsp_ok_in  = 1'b1;
            end else if (ring_next(tx_head_ff) != tx_tail_ff) begin
               tx_wr_en   = 1'b1;
               tx_head_in = ring_next(tx_head_ff);
               irq_en_in  = 1'b1;
               rsp_ok_in  = 1'b1;
            end
            // full ring: rejected, enable untouched
         end
         KIND_HOST_READ: begin
            if (!rx_empty) begin
               rsp_rdata_in = rx_store_ff[rx_tail_ff];
               rx_tail_in   = ring_next(rx_tail_ff);
               rsp_ok_in    = 1'b1;
            end
         end
         KIND_RX_BYTE: begin
            if (check_parity_ff && s1_perr_ff) begin
               rsp_drop_in = 1'b1;
            end else if (ring_next(rx_head_ff) == rx_tail_ff) begin
               rsp_drop_in = 1'b1;
            end else begin
               rx_wr_en   = 1'b1;
               rx_head_in = ring_next(rx_head_ff);
            end
         end
         KIND_TX_READY: begin
            if (tx_empty) begin
               irq_en_in = 1'b0;
            end else begin
               rsp_txv_in = 1'b1;
               rsp_txb_in = tx_store_ff[tx_tail_ff];
               tx_tail_in = ring_next(tx_tail_ff);
            end
         end
         KIND_RX_CLEAR: begin
            rx_head_in = '0;
            rx_tail_in = '0;
         end
         default: begin
            // unused kinds only report status
         end
      endcase

      rx_used         = ring_used(rx_head_in, rx_tail_in);
      tx_used         = ring_used(tx_head_in, tx_tail_in);
      rsp_rx_count_in = CNT_W'(rx_used);
      rsp_tx_space_in = CNT_W'(USED_W'(RING_DEPTH - 1) - tx_used);
   end

   // ------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         check_parity_ff <= 1'b1;
         rx_head_ff      <= '0;
         rx_tail_ff      <= '0;
         tx_head_ff      <= '0;
         tx_tail_ff      <= '0;
         irq_en_ff       <= 1'b0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            check_parity_ff <= csr_wr_data;
         end
         if (advance) begin
            rx_head_ff <= rx_head_in;
            rx_tail_ff <= rx_tail_in;
            tx_head_ff <= tx_head_in;
            tx_tail_ff <= tx_tail_in;
            irq_en_ff  <= irq_en_in;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // payload registers and stores
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_kind_ff  <= req_kind;
         s1_data_ff  <= req_data_byte;
         s1_perr_ff  <= req_parity_error;
         s1_txrdy_ff <= req_tx_ready;
      end
      if (advance) begin
         rsp_ok_ff       <= rsp_ok_in;
         rsp_rdata_ff    <= rsp_rdata_in;
         rsp_txv_ff      <= rsp_txv_in;
         rsp_txb_ff      <= rsp_txb_in;
         rsp_drop_ff     <= rsp_drop_in;
         rsp_rx_count_ff <= rsp_rx_count_in;
         rsp_tx_space_ff <= rsp_tx_space_in;
      end
      if (advance && rx_wr_en) begin
         rx_store_ff[rx_head_ff] <= s1_data_ff;
      end
      if (advance && tx_wr_en) begin
         tx_store_ff[tx_head_ff] <= s1_data_ff;
      end
   end

   // ------------------------------------------------------------------
   // outputs
   // ------------------------------------------------------------------
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_ok               = rsp_ok_ff;
   assign rsp_read_data        = rsp_rdata_ff;
   assign rsp_tx_valid         = rsp_txv_ff;
   assign rsp_tx_byte          = rsp_txb_ff;
   assign rsp_rx_dropped       = rsp_drop_ff;
   assign rsp_rx_count         = rsp_rx_count_ff;
   assign rsp_tx_space         = rsp_tx_space_ff;
   assign rsp_ready_irq_enable = irq_en_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // pointers stay inside the ring
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (rx_head_ff <= PTR_W'(RING_DEPTH - 1)) && (rx_tail_ff <= PTR_W'(RING_DEPTH - 1)) &&
      (tx_head_ff <= PTR_W'(RING_DEPTH - 1)) && (tx_tail_ff <= PTR_W'(RING_DEPTH - 1)))
      else $error("ring pointer out of range");

   // the ready interrupt is only armed by queuing a byte
   a_irq_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(irq_en_ff) |-> (tx_head_ff != tx_tail_ff))
      else $error("irq enable set with empty transmit ring");

   // ring state changes only when an item passes through
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(rx_head_ff) && $stable(rx_tail_ff) &&
                   $stable(tx_head_ff) && $stable(tx_tail_ff) && $stable(irq_en_ff))
      else $error("ring state changed without an item");

   // a result is never both accepted and dropped
   a_ok_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ok_ff && rsp_drop_ff))
      else $error("result flags both ok and dropped");

   // an item accepted into an empty input register is held there next cycle
   a_flow: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !s1_valid_ff) |=> s1_valid_ff)
      else $error("accepted item lost in input register");

endmodule
